FILE: hw/rtl/tdma_slot_allocator_core_macros.svh
// Assertion helpers, sampled on clock, off during reset.
`ifndef TDMA_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define TDMA_SLOT_ALLOCATOR_CORE_MACROS_SVH

`define TSA_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tsa implication check failed");

`define TSA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tsa next-cycle check failed");

`define TSA_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("tsa forbidden condition seen");

`endif

FILE: hw/rtl/tsa_pkg.sv
package tsa_pkg;

   localparam logic [1:0] REQ_SCHED = 2'd0;
   localparam logic [1:0] REQ_MERGE = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] REQ_NOP   = 2'd3;

   localparam logic [1:0] STAT_PLACED  = 2'd0;
   localparam logic [1:0] STAT_DUP     = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;
   localparam logic [1:0] STAT_CLEARED = 2'd3;

   localparam logic [3:0]  SF_MIN     = 4'd7;
   localparam logic [3:0]  SF_MAX     = 4'd12;
   localparam logic [12:0] SLOT_LIMIT = 13'd4095;

   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] channel;
      logic [7:0] src_node;
      logic [7:0] dst_node;
      logic [3:0] spread_factor;
   } tsa_req_type;

   typedef struct packed {
      logic [11:0] start_slot;
      logic [1:0]  status;
   } tsa_rsp_type;

   typedef struct packed {
      logic [7:0]  src;
      logic [7:0]  dst;
      logic [3:0]  sf;
      logic [11:0] start;
   } tsa_entry_type;

   typedef struct packed {
      logic [7:0]  src;
      logic [7:0]  dst;
      logic [3:0]  sf;
      logic [11:0] start;
      logic [5:0]  dur;
   } tsa_cmp_req_type;

   typedef struct packed {
      logic dup;
      logic conflict;
   } tsa_cmp_res_type;

   function automatic logic [5:0] dur_of(input logic [3:0] sf);
      logic [3:0] sh;
      sh = sf - SF_MIN;
      return 6'(6'd1 << sh[2:0]);
   endfunction

endpackage

FILE: hw/rtl/tsa_table.sv
module tsa_table #(
   parameter int DEPTH = 64,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  tsa_pkg::tsa_entry_type wr_data,
   input  logic                  rd_en,
   input  logic [IDX_W-1:0]      rd_addr,
   output tsa_pkg::tsa_entry_type rd_data
);
   import tsa_pkg::*;

   tsa_entry_type mem [DEPTH];
   tsa_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/tsa_cmp_unit.sv
module tsa_cmp_unit (
   input  tsa_pkg::tsa_entry_type   entry,
   input  tsa_pkg::tsa_cmp_req_type creq,
   output tsa_pkg::tsa_cmp_res_type cres
);
   import tsa_pkg::*;

   logic [12:0] e_start;
   logic [12:0] e_end;
   logic [12:0] c_start;
   logic [12:0] c_end;
   logic        overlap;
   logic        shared;

   always_comb begin
      e_start = {1'b0, entry.start};
      e_end   = e_start + 13'(dur_of(entry.sf));
      c_start = {1'b0, creq.start};
      c_end   = c_start + 13'(creq.dur);
      overlap = (e_start < c_end) && (e_end > c_start);
      shared  = (entry.src == creq.src) || (entry.src == creq.dst) ||
                (entry.dst == creq.src) || (entry.dst == creq.dst);
      cres.conflict = overlap && shared;
      cres.dup      = (entry.src == creq.src) && (entry.dst == creq.dst) &&
                      (entry.sf == creq.sf);
   end

endmodule

FILE: hw/rtl/tdma_slot_allocator_core.sv
// Clear, and schedule with a full table, go straight to the done state. Merge first makes
// a duplicate pass over the entries, cut short by a hit, and stops there if the table is
// full. Schedule, and merge after it, reads the channel's next free slot, loads it as the
// candidate, stopping if it has no room, and scans the entries, stepping it on a conflict.
// Throughput: one request in flight; the next is accepted once the response is registered.
// Reset: control, entry count and per-channel valid bits clear; table contents undefined.
`include "tdma_slot_allocator_core_macros.svh"

module tdma_slot_allocator_core #(
   parameter int TABLE_DEPTH = 64,
   parameter int CHAN_COUNT  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tsa_pkg::tsa_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tsa_pkg::tsa_rsp_type rsp_data
);
   import tsa_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CH_W  = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DUP  = 3'd1;
   localparam logic [2:0] ST_NFS  = 3'd2;
   localparam logic [2:0] ST_LOAD = 3'd3;
   localparam logic [2:0] ST_SCAN = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   function automatic logic [CH_W-1:0] chan_mod(input logic [3:0] c);
      logic [6:0] v;
      v = {3'd0, c};
      for (int i = 0; i < 8; i++) begin
         if (v >= 7'(CHAN_COUNT)) begin
            v = v - 7'(CHAN_COUNT);
         end
      end
      return v[CH_W-1:0];
   endfunction

   function automatic logic [3:0] sf_sat(input logic [3:0] sf);
      if (sf < SF_MIN) return SF_MIN;
      if (sf > SF_MAX) return SF_MAX;
      return sf;
   endfunction

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [11:0]      cand_ff, cand_in;
   logic [CH_W-1:0]  chan_ff, chan_in;
   logic [7:0]       src_ff, src_in;
   logic [7:0]       dst_ff, dst_in;
   logic [3:0]       sf_ff, sf_in;
   logic [11:0]      res_start_ff, res_start_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   tsa_rsp_type      rsp_data_ff, rsp_data_in;
   logic [CHAN_COUNT-1:0] nfs_vld_ff, nfs_vld_in;

   logic [11:0] nfs_mem [CHAN_COUNT];
   logic [11:0] nfs_q_ff;
   logic        nfs_qv_ff;

   logic            req_acc;
   logic            issue;
   logic            scan_done;
   logic            full;
   logic            tbl_rd_en;
   logic            tbl_wr_en;
   logic            nfs_rd_en;
   logic            nfs_wr_en;
   logic            rsp_load;
   logic [5:0]      dur;
   logic [11:0]     load_s;
   logic [12:0]     load_end;
   logic [12:0]     cand_p1;
   logic [12:0]     cand_end;
   logic [12:0]     next_end;
   tsa_entry_type   tbl_wr_data;
   tsa_entry_type   tbl_rd_data;
   tsa_cmp_req_type creq;
   tsa_cmp_res_type cres;

   assign req_acc = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign dur = dur_of(sf_ff);
   assign issue = (rd_idx_ff < cnt_ff);
   assign scan_done = !issue && !cmp_vld_ff;
   assign full = (cnt_ff >= CNT_W'(TABLE_DEPTH));
   assign load_s = nfs_qv_ff ? nfs_q_ff : 12'd0;
   assign load_end = {1'b0, load_s} + 13'(dur);
   assign cand_p1 = {1'b0, cand_ff} + 13'd1;
   assign cand_end = {1'b0, cand_ff} + 13'(dur);
   assign next_end = cand_p1 + 13'(dur);

   assign tbl_wr_data = '{src: src_ff, dst: dst_ff, sf: sf_ff, start: cand_ff};
   assign creq = '{src: src_ff, dst: dst_ff, sf: sf_ff, start: cand_ff, dur: dur};

   tsa_table #(
      .DEPTH(TABLE_DEPTH),
      .IDX_W(IDX_W)
   ) u_table (
      .clock  (clock),
      .wr_en  (tbl_wr_en),
      .wr_addr(cnt_ff[IDX_W-1:0]),
      .wr_data(tbl_wr_data),
      .rd_en  (tbl_rd_en),
      .rd_addr(rd_idx_ff[IDX_W-1:0]),
      .rd_data(tbl_rd_data)
   );

   tsa_cmp_unit u_cmp (
      .entry(tbl_rd_data),
      .creq (creq),
      .cres (cres)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_vld_in    = cmp_vld_ff;
      cand_in       = cand_ff;
      chan_in       = chan_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      sf_in         = sf_ff;
      res_start_in  = res_start_ff;
      res_status_in = res_status_ff;
      nfs_vld_in    = nfs_vld_ff;
      tbl_rd_en     = 1'b0;
      tbl_wr_en     = 1'b0;
      nfs_rd_en     = 1'b0;
      nfs_wr_en     = 1'b0;
      rsp_load      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               chan_in      = chan_mod(req_data.channel);
               src_in       = req_data.src_node;
               dst_in       = req_data.dst_node;
               sf_in        = sf_sat(req_data.spread_factor);
               res_start_in = 12'd0;
               rd_idx_in    = '0;
               cmp_vld_in   = 1'b0;
               unique case (req_data.req_type)
                  REQ_CLEAR: begin
                     cnt_in        = '0;
                     nfs_vld_in    = '0;
                     res_status_in = STAT_CLEARED;
                     state_in      = ST_DONE;
                  end
                  REQ_MERGE: begin
                     state_in = ST_DUP;
                  end
                  REQ_SCHED: begin
                     if (full) begin
                        res_status_in = STAT_FULL;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_NFS;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DUP: begin
            tbl_rd_en  = issue;
            rd_idx_in  = rd_idx_ff + CNT_W'(issue);
            cmp_vld_in = issue;
            if (cmp_vld_ff && cres.dup) begin
               res_status_in = STAT_DUP;
               state_in      = ST_DONE;
            end else if (scan_done) begin
               if (full) begin
                  res_status_in = STAT_FULL;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_NFS;
               end
            end
         end
         ST_NFS: begin
            nfs_rd_en = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            cand_in    = load_s;
            rd_idx_in  = '0;
            cmp_vld_in = 1'b0;
            if (load_end > SLOT_LIMIT) begin
               res_status_in = STAT_FULL;
               state_in      = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            tbl_rd_en  = issue;
            rd_idx_in  = rd_idx_ff + CNT_W'(issue);
            cmp_vld_in = issue;
            if (cmp_vld_ff && cres.conflict) begin
               rd_idx_in  = '0;
               cmp_vld_in = 1'b0;
               if (next_end > SLOT_LIMIT) begin
                  res_status_in = STAT_FULL;
                  state_in      = ST_DONE;
               end else begin
                  cand_in = cand_p1[11:0];
               end
            end else if (scan_done) begin
               tbl_wr_en                = 1'b1;
               nfs_wr_en                = 1'b1;
               cnt_in                   = cnt_ff + CNT_W'(1);
               nfs_vld_in[chan_ff]      = 1'b1;
               res_start_in             = cand_ff;
               res_status_in            = STAT_PLACED;
               state_in                 = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_load ? tsa_rsp_type'{start_slot: res_start_ff, status: res_status_ff}
                              : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rd_idx_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         nfs_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         nfs_vld_ff   <= nfs_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff       <= cand_in;
      chan_ff       <= chan_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      sf_ff         <= sf_in;
      res_start_ff  <= res_start_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (nfs_wr_en) begin
         nfs_mem[chan_ff] <= cand_end[11:0];
      end
      if (nfs_rd_en) begin
         nfs_q_ff  <= nfs_mem[chan_ff];
         nfs_qv_ff <= nfs_vld_ff[chan_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TSA_ASSERT_NEVER(a_cnt_bound, cnt_ff > CNT_W'(TABLE_DEPTH))
   `TSA_ASSERT_IMPL(a_wr_room, tbl_wr_en, cnt_ff < CNT_W'(TABLE_DEPTH))
   `TSA_ASSERT_IMPL(a_cand_fits, state_ff == ST_SCAN, cand_end <= SLOT_LIMIT)
   `TSA_ASSERT_NEXT(a_cnt_step, tbl_wr_en, cnt_ff == $past(cnt_ff) + CNT_W'(1))

endmodule
